FILE: rtl/ptt_pkg.sv
// shared types and constants for the priority task table
package ptt_pkg;

  localparam int USER_BITS     = 16;
  localparam int TASK_ID_BITS  = 10;
  localparam int PRIO_REQ_BITS = 30;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_EDIT   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_EXEC   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDIT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [USER_BITS-1:0] user;
  } result_t;

endpackage

FILE: rtl/ptt_mem.sv
// task slot memory, one write port and one registered read port
module ptt_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 47
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/ptt_ctrl.sv
// sequencer for add, edit, remove, top search and the post-reset clearing sweep
module ptt_ctrl
  import ptt_pkg::*;
#(
  parameter int TASK_SLOTS    = 1024,
  parameter int PRIORITY_BITS = 30,
  parameter int AW            = 10,
  parameter int DW            = 47
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic [USER_BITS-1:0]     user_id,
  input  logic [TASK_ID_BITS-1:0]  task_id,
  input  logic [PRIO_REQ_BITS-1:0] priority_req,
  input  logic                     res_ready,
  output result_t                  res,
  output logic                     mem_wr_en,
  output logic [AW-1:0]            mem_wr_addr,
  output logic [DW-1:0]            mem_wr_data,
  output logic [AW-1:0]            mem_rd_addr,
  input  logic [DW-1:0]            mem_rd_data
);

  localparam int PB = PRIORITY_BITS;
  localparam int CW = (AW + 1 > TASK_ID_BITS) ? AW + 1 : TASK_ID_BITS;
  localparam int PW = (PB > PRIO_REQ_BITS) ? PB : PRIO_REQ_BITS;
  localparam logic [AW-1:0] LAST = AW'(TASK_SLOTS - 1);

  state_t state, state_next;
  action_t act;

  logic [CW-1:0] tid_wide;
  logic [AW-1:0] tid_addr;
  logic          in_range;
  logic [PW-1:0] prio_wide;
  logic [PB-1:0] prio_in;

  logic                 rd_live;
  logic [USER_BITS-1:0] rd_owner;
  logic [PB-1:0]        rd_prio;

  logic [AW-1:0]        sweep_addr;
  logic                 sweep_last;
  logic [AW-1:0]        op_addr;
  logic [PB-1:0]        op_prio;
  logic                 found;
  logic [PB-1:0]        best_prio;
  logic [AW-1:0]        best_slot;
  logic [USER_BITS-1:0] best_owner;
  logic                 better;

  assign act       = action_t'(action);
  assign tid_wide  = CW'(task_id);
  assign tid_addr  = tid_wide[AW-1:0];
  assign in_range  = tid_wide < CW'(TASK_SLOTS);
  assign prio_wide = PW'(priority_req);
  assign prio_in   = prio_wide[PB-1:0];

  assign rd_live  = mem_rd_data[DW-1];
  assign rd_owner = mem_rd_data[PB +: USER_BITS];
  assign rd_prio  = mem_rd_data[PB-1:0];

  assign sweep_last = (sweep_addr == LAST);
  assign better     = rd_live && (!found || (rd_prio >= best_prio));

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    mem_wr_en   = 1'b0;
    mem_wr_addr = op_addr;
    mem_wr_data = '0;
    mem_rd_addr = tid_addr;
    res         = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = sweep_addr;
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (act)
            ACT_ADD: begin
              mem_wr_en   = in_range;
              mem_wr_addr = tid_addr;
              mem_wr_data = {1'b1, user_id, prio_in};
            end
            ACT_EDIT: begin
              if (in_range) begin
                state_next = ST_EDIT;
              end
            end
            ACT_REMOVE: begin
              mem_wr_en   = in_range;
              mem_wr_addr = tid_addr;
            end
            ACT_EXEC: begin
              mem_rd_addr = '0;
              state_next  = ST_SCAN;
            end
          endcase
        end
      end
      ST_EDIT: begin
        mem_wr_en   = rd_live;
        mem_wr_data = {1'b1, rd_owner, op_prio};
        state_next  = ST_IDLE;
      end
      ST_SCAN: begin
        mem_rd_addr = sweep_addr + 1'b1;
        if (sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          res.valid   = 1'b1;
          res.found   = found;
          res.user    = found ? best_owner : '0;
          mem_wr_en   = found;
          mem_wr_addr = best_slot;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep_addr <= '0;
      found      <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
        end
        ST_IDLE: begin
          op_addr    <= tid_addr;
          op_prio    <= prio_in;
          found      <= 1'b0;
          sweep_addr <= '0;
        end
        ST_SCAN: begin
          if (better) begin
            found      <= 1'b1;
            best_prio  <= rd_prio;
            best_slot  <= sweep_addr;
            best_owner <= rd_owner;
          end
          if (!sweep_last) begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/priority_task_table_top.sv
// top level of the priority task table: memory, sequencer and result register
//
//   channel | valid / stall          | payload
//   --------+------------------------+------------------------------------------
//   input   | in_valid / in_stall    | action, user_id, task_id, priority_req
//   output  | out_valid / out_stall  | top_user, top_found
//
// add and remove write the slot directly, edit reads it first (read then conditional write)
// execute top makes one memory read per slot, then the write-back
// after reset a clearing sweep over all TASK_SLOTS slots runs with in_stall high
// a result waits in the output register while the next item is taken
// out_stall only holds an execute top in its final cycle until the register frees
module priority_task_table_top
  import ptt_pkg::*;
#(
  parameter int TASK_SLOTS    = 1024,
  parameter int PRIORITY_BITS = 30
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic [USER_BITS-1:0]     user_id,
  input  logic [TASK_ID_BITS-1:0]  task_id,
  input  logic [PRIO_REQ_BITS-1:0] priority_req,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [USER_BITS-1:0]     top_user,
  output logic                     top_found
);

  localparam int AW = $clog2(TASK_SLOTS);
  localparam int DW = 1 + USER_BITS + PRIORITY_BITS;

  result_t       res;
  logic          res_ready;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [DW-1:0] mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  logic [DW-1:0] mem_rd_data;

  assign res_ready = !out_valid || !out_stall;

  ptt_mem #(
    .DEPTH (TASK_SLOTS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ptt_ctrl #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .AW            (AW),
    .DW            (DW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .user_id      (user_id),
    .task_id      (task_id),
    .priority_req (priority_req),
    .res_ready    (res_ready),
    .res          (res),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res.valid) begin
      top_user  <= res.user;
      top_found <= res.found;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!out_valid || !out_stall))
    else $error("result issued while output register holds an untaken transfer");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> out_valid)
    else $error("result did not reach the output register");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !top_found) |-> (top_user == '0))
    else $error("empty-table result carries a nonzero user");

  a_exec_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (action == ACT_EXEC)) |=> in_stall)
    else $error("input taken while a top search is running");

endmodule
